// ===== hw/rtl/cdd_pkg.sv =====
// shared types and constants for the cycle-detect duplicate finder
package cdd_pkg;

   localparam int N_MAX_DEFAULT = 1024;
   localparam int VALUE_WIDTH   = 10;
   localparam int STATUS_WIDTH  = 2;

   localparam logic [STATUS_WIDTH-1:0] STATUS_FOUND = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_SHORT = 2'd2;

   typedef enum logic [3:0] {
      WALK_IDLE,
      WALK_SLOW,
      WALK_FAST1,
      WALK_FAST2,
      WALK_CHECK,
      WALK_START2,
      WALK_A,
      WALK_B,
      WALK_DONE
   } walk_state_type;

   typedef struct packed {
      logic idle;
      logic done;
   } walk_status_type;

endpackage

// ===== hw/rtl/cycle_detect_duplicate_finder.sv =====
// duplicate finder top: element loading, range checks, result register
// loading: one element per cycle while req_ready is high; a short or bad array shows its result
//   in the cycle after the closing element is taken; a good one after the tortoise/hare walk,
//   the second walk and the load of the result register (one shared read port)
// throughput: one array at a time; no new transaction is taken during the walk
// reset: synchronous, clears counters, flags and the sequencer; memory is not cleared
module cycle_detect_duplicate_finder #(
   parameter int N_MAX = cdd_pkg::N_MAX_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cdd_pkg::VALUE_WIDTH-1:0]   req_value,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cdd_pkg::VALUE_WIDTH-1:0]   rsp_duplicate,
   output logic [cdd_pkg::STATUS_WIDTH-1:0]  rsp_status
);
   import cdd_pkg::*;

   localparam int AW = $clog2(N_MAX);
   localparam int CW = $clog2(N_MAX + 1);
   localparam int MW = (CW > VALUE_WIDTH) ? CW : VALUE_WIDTH;

   logic [CW-1:0]           count_ff, count_in;
   logic                    zero_seen_ff, zero_seen_in;
   logic                    overflow_ff, overflow_in;
   logic [VALUE_WIDTH-1:0]  max_ff, max_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]  rsp_dup_ff, rsp_dup_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;

   logic                    rsp_free;
   logic                    accept;
   logic                    has_room;
   logic [CW-1:0]           count_final;
   logic [VALUE_WIDTH-1:0]  max_final;
   logic                    zero_final;
   logic                    bad_array;
   logic                    short_array;

   logic                    walk_start;
   logic                    walk_ack;
   walk_status_type         walk_status;
   logic [VALUE_WIDTH-1:0]  walk_dup;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [AW-1:0]           rd_addr;
   logic [VALUE_WIDTH-1:0]  rd_data;

   cdd_store #(
      .N_MAX (N_MAX),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cdd_walk #(
      .AW (AW)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .start     (walk_start),
      .ack       (walk_ack),
      .status    (walk_status),
      .duplicate (walk_dup),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         zero_seen_ff <= 1'b0;
         overflow_ff  <= 1'b0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         zero_seen_ff <= zero_seen_in;
         overflow_ff  <= overflow_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_dup_ff    <= rsp_dup_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = walk_status.idle && rsp_free;
   assign accept    = req_valid && req_ready;
   assign has_room  = (count_ff != CW'(N_MAX));
   assign wr_en     = accept && has_room;
   assign wr_addr   = count_ff[AW-1:0];
   assign walk_ack  = walk_status.done && rsp_free;

   // view of the array including the transaction being taken
   assign count_final = has_room ? count_ff + CW'(1) : count_ff;
   assign max_final   = (has_room && (req_value > max_ff)) ? req_value : max_ff;
   assign zero_final  = zero_seen_ff || (has_room && (req_value == '0));
   assign bad_array   = overflow_ff || !has_room || zero_final ||
                        (MW'(max_final) >= MW'(count_final));
   assign short_array = (count_final < CW'(2));

   always_comb begin
      count_in      = count_ff;
      zero_seen_in  = zero_seen_ff;
      overflow_in   = overflow_ff;
      max_in        = max_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_dup_in    = rsp_dup_ff;
      rsp_status_in = rsp_status_ff;
      walk_start    = 1'b0;
      if (walk_ack) begin
         rsp_valid_in  = 1'b1;
         rsp_dup_in    = walk_dup;
         rsp_status_in = STATUS_FOUND;
      end
      if (accept) begin
         if (req_last) begin
            count_in     = '0;
            zero_seen_in = 1'b0;
            overflow_in  = 1'b0;
            max_in       = '0;
            if (short_array) begin
               rsp_valid_in  = 1'b1;
               rsp_dup_in    = '0;
               rsp_status_in = STATUS_SHORT;
            end else if (bad_array) begin
               rsp_valid_in  = 1'b1;
               rsp_dup_in    = '0;
               rsp_status_in = STATUS_RANGE;
            end else begin
               walk_start = 1'b1;
            end
         end else begin
            count_in     = count_final;
            zero_seen_in = zero_final;
            overflow_in  = overflow_ff || !has_room;
            max_in       = max_final;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_duplicate = rsp_dup_ff;
   assign rsp_status    = rsp_status_ff;

   // a found duplicate is a valid index, never element 0
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FOUND) |-> rsp_duplicate != '0)
      else $error("found status with zero duplicate");

   // error results carry no duplicate
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_FOUND) |-> rsp_duplicate == '0)
      else $error("error status with nonzero duplicate");

   // loaded count never passes the store depth
   assert property (@(posedge clock) disable iff (reset)
      MW'(count_ff) <= MW'(N_MAX))
      else $error("element count beyond store depth");

   // a walk starts only from an idle sequencer and leaves it busy
   assert property (@(posedge clock) disable iff (reset)
      walk_start |=> !walk_status.idle)
      else $error("walk start not taken");

endmodule

// ===== hw/rtl/cdd_store.sv =====
// element memory: one write port, one registered read port
module cdd_store #(
   parameter int N_MAX = cdd_pkg::N_MAX_DEFAULT,
   parameter int AW    = 10
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [AW-1:0]                    wr_addr,
   input  logic [cdd_pkg::VALUE_WIDTH-1:0]  wr_data,
   input  logic [AW-1:0]                    rd_addr,
   output logic [cdd_pkg::VALUE_WIDTH-1:0]  rd_data
);
   import cdd_pkg::*;

   logic [VALUE_WIDTH-1:0] mem [N_MAX];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/cdd_walk.sv =====
// pointer-walk sequencer: tortoise/hare phase, then cycle entry phase
module cdd_walk #(
   parameter int AW = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             ack,
   output cdd_pkg::walk_status_type         status,
   output logic [cdd_pkg::VALUE_WIDTH-1:0]  duplicate,
   output logic [AW-1:0]                    rd_addr,
   input  logic [cdd_pkg::VALUE_WIDTH-1:0]  rd_data
);
   import cdd_pkg::*;

   walk_state_type         state_ff, state_in;
   logic [VALUE_WIDTH-1:0] slow_ff, slow_in;
   logic [VALUE_WIDTH-1:0] fast_ff, fast_in;
   logic [VALUE_WIDTH-1:0] cmp_a, cmp_b;
   logic                   cmp_eq;
   logic [VALUE_WIDTH-1:0] addr_value;

   // single shared equality unit
   assign cmp_eq = (cmp_a == cmp_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WALK_IDLE;
      end else begin
         state_ff <= state_in;
      end
      slow_ff <= slow_in;
      fast_ff <= fast_in;
   end

   always_comb begin
      state_in   = state_ff;
      slow_in    = slow_ff;
      fast_in    = fast_ff;
      addr_value = slow_ff;
      cmp_a      = rd_data;
      cmp_b      = slow_ff;
      case (state_ff)
         WALK_IDLE: begin
            if (start) begin
               slow_in  = '0;
               fast_in  = '0;
               state_in = WALK_SLOW;
            end
         end
         WALK_SLOW: begin
            addr_value = slow_ff;
            state_in   = WALK_FAST1;
         end
         WALK_FAST1: begin
            addr_value = fast_ff;
            slow_in    = rd_data;
            state_in   = WALK_FAST2;
         end
         WALK_FAST2: begin
            // second hop of the fast pointer
            addr_value = rd_data;
            state_in   = WALK_CHECK;
         end
         WALK_CHECK: begin
            cmp_a = rd_data;
            cmp_b = slow_ff;
            if (cmp_eq) begin
               // fast pointer now walks from element 0
               fast_in  = '0;
               state_in = WALK_START2;
            end else begin
               fast_in    = rd_data;
               addr_value = slow_ff;
               state_in   = WALK_FAST1;
            end
         end
         WALK_START2: begin
            cmp_a = fast_ff;
            cmp_b = slow_ff;
            if (cmp_eq) begin
               state_in = WALK_DONE;
            end else begin
               addr_value = fast_ff;
               state_in   = WALK_A;
            end
         end
         WALK_A: begin
            addr_value = slow_ff;
            fast_in    = rd_data;
            state_in   = WALK_B;
         end
         WALK_B: begin
            slow_in = rd_data;
            cmp_a   = rd_data;
            cmp_b   = fast_ff;
            if (cmp_eq) begin
               state_in = WALK_DONE;
            end else begin
               addr_value = fast_ff;
               state_in   = WALK_A;
            end
         end
         WALK_DONE: begin
            if (ack) begin
               state_in = WALK_IDLE;
            end
         end
         default: begin
            state_in = WALK_IDLE;
         end
      endcase
   end

   assign rd_addr     = AW'(addr_value);
   assign status.idle = (state_ff == WALK_IDLE);
   assign status.done = (state_ff == WALK_DONE);
   assign duplicate   = fast_ff;

endmodule
